/* hw/rtl/csvfc_pkg.sv */
// ----------------------------------------------------------------------------
// csvfc_pkg
// Shared constants, result kinds and item types of the CSV field classifier.
// ----------------------------------------------------------------------------
package csvfc_pkg;

  localparam int unsigned MAX_FIELDS   = 16;
  localparam int unsigned FIELD_CNT_W  = 5;

  localparam logic [31:0] HASH_SEED    = 32'd5381;
  localparam logic [31:0] SHORT_LIMIT  = 32'd8;
  localparam int unsigned HASH_SHIFT   = 5;

  localparam logic [7:0]  CH_COMMA     = 8'h2C;
  localparam logic [7:0]  CH_NEWLINE   = 8'h0A;
  localparam logic [7:0]  CH_QUOTE     = 8'h22;
  localparam logic [7:0]  CH_PLUS      = 8'h2B;
  localparam logic [7:0]  CH_MINUS     = 8'h2D;
  localparam logic [7:0]  CH_ZERO      = 8'h30;
  localparam logic [7:0]  CH_NINE      = 8'h39;

  localparam logic [2:0]  KIND_NULL    = 3'd0;
  localparam logic [2:0]  KIND_INT     = 3'd1;
  localparam logic [2:0]  KIND_RAW     = 3'd2;
  localparam logic [2:0]  KIND_QUOTED  = 3'd3;
  localparam logic [2:0]  KIND_ERROR   = 3'd4;
  localparam logic [2:0]  KIND_SHORT   = 3'd5;

  typedef struct packed {
    logic        mode;
    logic [7:0]  data_byte;
    logic [31:0] byte_offset;
    logic        last_in_line;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         field_kind;
    logic [2:0]         short_length;
    logic [31:0]        field_hash;
    logic signed [63:0] field_value;
    logic [31:0]        string_offset;
    logic [31:0]        string_length;
    logic [3:0]         field_number;
    logic               line_done;
  } out_item_t;

endpackage

/* hw/rtl/csv_field_classifier.sv */
// ----------------------------------------------------------------------------
// csv_field_classifier
// A result passes from the input register through the parser into the result register.
// Throughput: one byte item per cycle while no null fill runs and out_ready
// does not stall; the result register and output handshake set that figure,
// one result leaving per cycle. At a line end each missing field gives a null
// result. Reset (synchronous, rst_n low) empties both registers, clears the line
// state and sets the field count nf_r to 16.
// ----------------------------------------------------------------------------
module csv_field_classifier
  import csvfc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [FIELD_CNT_W-1:0] cfg_wr_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data
);

  logic      take;
  logic      item_vld;
  in_item_t  item;
  logic      adv;
  logic      res_vld;
  out_item_t res;

  csvfc_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .take     (take),
    .item_vld (item_vld),
    .item     (item)
  );

  csvfc_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_vld    (item_vld),
    .item        (item),
    .adv         (adv),
    .take        (take),
    .res_vld     (res_vld),
    .res         (res)
  );

  csvfc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_vld   (res_vld),
    .res       (res),
    .adv       (adv),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* hw/rtl/csvfc_in_reg.sv */
// ----------------------------------------------------------------------------
// csvfc_in_reg
// Input register that holds one item until the parser consumes it.
// ----------------------------------------------------------------------------
module csvfc_in_reg
  import csvfc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     take,
  output logic     item_vld,
  output in_item_t item
);

  logic     vld_r;
  logic     vld_nxt;
  in_item_t item_r;

  assign in_ready = !vld_r || take;
  assign vld_nxt  = in_ready ? in_valid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

/* hw/rtl/csvfc_parser.sv */
// ----------------------------------------------------------------------------
// csvfc_parser
// Field state, per-byte parsing, field close and null fill at line end.
// ----------------------------------------------------------------------------
module csvfc_parser
  import csvfc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [FIELD_CNT_W-1:0] cfg_wr_data,
  input  logic                   item_vld,
  input  in_item_t               item,
  input  logic                   adv,
  output logic                   take,
  output logic                   res_vld,
  output out_item_t              res
);

  localparam logic [1:0] PH_START      = 2'd0;
  localparam logic [1:0] PH_RAW        = 2'd1;
  localparam logic [1:0] PH_QUOTED     = 2'd2;
  localparam logic [1:0] PH_QUOTE_SEEN = 2'd3;

  typedef struct packed {
    logic [1:0]  phase;
    logic [31:0] clen;
    logic [31:0] hash;
    logic        neg;
    logic [63:0] sv;
    logic        ip;
    logic        quoted;
    logic        sdq;
    logic [63:0] sbytes;
    logic [31:0] cstart;
  } fstate_t;

  localparam fstate_t FIELD_CLEAR = '{
    phase:  PH_START,
    clen:   32'd0,
    hash:   HASH_SEED,
    neg:    1'b0,
    sv:     64'd0,
    ip:     1'b1,
    quoted: 1'b0,
    sdq:    1'b0,
    sbytes: 64'd0,
    cstart: 32'd0
  };

  fstate_t                st_r, st_nxt, s1;
  logic [FIELD_CNT_W-1:0] fe_r, fe_nxt, fe1;
  logic [FIELD_CNT_W-1:0] nf_r, cnt;
  logic                   fill_r, fill_nxt;
  logic                   step, gate, eol, sep, qt;
  logic                   do_close, do_err, close_now, emit;
  logic [7:0]             b;

  function automatic fstate_t add_byte(fstate_t s, logic [7:0] c);
    fstate_t     r;
    logic [31:0] ext;
    logic        dig;
    logic [63:0] dv;
    r   = s;
    ext = {{24{c[7]}}, c};
    dig = (c >= CH_ZERO) && (c <= CH_NINE);
    dv  = {56'd0, c - CH_ZERO};
    if (s.clen < SHORT_LIMIT) begin
      r.sbytes[{s.clen[2:0], 3'b000} +: 8] = c;
    end
    if (s.clen != '1) begin
      r.clen = s.clen + 32'd1;
    end
    r.hash = ((s.hash << HASH_SHIFT) + s.hash) ^ ext;
    if (s.ip) begin
      if (s.clen == 32'd0) begin
        if (c == CH_PLUS) begin
          r.neg = 1'b0;
        end else if (c == CH_MINUS) begin
          r.neg = 1'b1;
        end else if (dig) begin
          r.sv = dv;
        end else begin
          r.ip = 1'b0;
        end
      end else if (dig) begin
        // The running value carries its sign, so no negation is needed at close.
        r.sv = (s.sv << 3) + (s.sv << 1) + (s.neg ? (64'd0 - dv) : dv);
      end else begin
        r.ip = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic out_item_t mk_res(logic [2:0] kind, logic [FIELD_CNT_W-1:0] fe,
                                       logic [FIELD_CNT_W-1:0] n);
    out_item_t r;
    r              = '0;
    r.field_kind   = kind;
    r.field_number = fe[3:0];
    r.line_done    = (fe + FIELD_CNT_W'(1)) == n;
    return r;
  endfunction

  function automatic out_item_t close_res(fstate_t s, logic [FIELD_CNT_W-1:0] fe,
                                          logic [FIELD_CNT_W-1:0] n);
    out_item_t r;
    r = mk_res(KIND_NULL, fe, n);
    if (s.clen == 32'd0 && !s.quoted) begin
      r.field_kind = KIND_NULL;
    end else if (s.ip) begin
      r.field_kind  = KIND_INT;
      r.field_hash  = s.hash;
      r.field_value = s.sv;
    end else if (s.clen < SHORT_LIMIT) begin
      r.field_kind   = KIND_SHORT;
      r.short_length = s.clen[2:0];
      r.field_hash   = s.hash;
      r.field_value  = s.sbytes;
    end else begin
      r.field_kind    = s.sdq ? KIND_QUOTED : KIND_RAW;
      r.field_hash    = s.hash;
      r.string_offset = s.cstart;
      r.string_length = s.clen;
    end
    return r;
  endfunction

  assign cnt = (nf_r == '0) ? FIELD_CNT_W'(1) :
               (nf_r > FIELD_CNT_W'(MAX_FIELDS)) ? FIELD_CNT_W'(MAX_FIELDS) : nf_r;

  assign step = adv && (fill_r || item_vld);
  assign take = adv && !fill_r && item_vld;
  assign b    = item.data_byte;
  assign sep  = (b == CH_COMMA) || (b == CH_NEWLINE);
  assign qt   = (b == CH_QUOTE);
  assign eol  = item.mode || item.last_in_line;
  assign gate = fe_r < cnt;

  always_comb begin
    s1       = st_r;
    do_close = 1'b0;
    do_err   = 1'b0;
    if (!item.mode && gate) begin
      unique case (st_r.phase)
        PH_START: begin
          if (sep) begin
            do_close = 1'b1;
          end else if (qt) begin
            s1.quoted = 1'b1;
            s1.ip     = 1'b0;
            s1.cstart = item.byte_offset + 32'd1;
            s1.phase  = PH_QUOTED;
          end else begin
            s1        = add_byte(st_r, b);
            s1.cstart = item.byte_offset;
            s1.phase  = PH_RAW;
          end
        end
        PH_RAW: begin
          if (sep) begin
            do_close = 1'b1;
          end else begin
            s1 = add_byte(st_r, b);
          end
        end
        PH_QUOTED: begin
          if (qt) begin
            s1.phase = PH_QUOTE_SEEN;
          end else begin
            s1 = add_byte(st_r, b);
          end
        end
        PH_QUOTE_SEEN: begin
          if (qt) begin
            s1       = add_byte(st_r, b);
            s1.sdq   = 1'b1;
            s1.phase = PH_QUOTED;
          end else if (sep) begin
            do_close = 1'b1;
          end else begin
            do_err = 1'b1;
          end
        end
      endcase
    end
  end

  assign close_now = do_close || (eol && s1.phase != PH_START);
  assign emit      = gate && (do_err || close_now);
  assign fe1       = fe_r + {{(FIELD_CNT_W-1){1'b0}}, emit};

  always_comb begin
    st_nxt   = st_r;
    fe_nxt   = fe_r;
    fill_nxt = fill_r;
    res      = mk_res(KIND_NULL, fe_r, cnt);
    res_vld  = 1'b0;
    if (fill_r) begin
      res_vld = step;
      if (step) begin
        if ((fe_r + FIELD_CNT_W'(1)) >= cnt) begin
          fe_nxt   = '0;
          fill_nxt = 1'b0;
        end else begin
          fe_nxt = fe_r + FIELD_CNT_W'(1);
        end
      end
    end else begin
      res     = do_err ? mk_res(KIND_ERROR, fe_r, cnt) : close_res(s1, fe_r, cnt);
      res_vld = step && emit;
      if (step) begin
        st_nxt = (do_err || close_now || eol) ? FIELD_CLEAR : s1;
        if (eol) begin
          fe_nxt   = (fe1 < cnt) ? fe1 : '0;
          fill_nxt = fe1 < cnt;
        end else begin
          fe_nxt = fe1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= FIELD_CLEAR;
      fe_r   <= '0;
      fill_r <= 1'b0;
      nf_r   <= FIELD_CNT_W'(MAX_FIELDS);
    end else begin
      st_r   <= st_nxt;
      fe_r   <= fe_nxt;
      fill_r <= fill_nxt;
      if (cfg_wr_en) begin
        nf_r <= cfg_wr_data;
      end
    end
  end

  a_fe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fe_r <= FIELD_CNT_W'(MAX_FIELDS))
    else $error("Field counter exceeds the maximum field count.");

  a_fill_clear: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r |-> (st_r.phase == PH_START))
    else $error("Null fill runs while a field is open.");

  a_quote_state: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == PH_QUOTED || st_r.phase == PH_QUOTE_SEEN || st_r.sdq) |-> st_r.quoted)
    else $error("Quoted phase without a quoted field.");

  a_fill_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r && adv) |-> (res_vld && !take))
    else $error("Null fill step did not produce a result.");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> (!fill_r && fe_r == '0))
    else $error("Line state not cleared by reset.");

endmodule

/* hw/rtl/csvfc_out_reg.sv */
// ----------------------------------------------------------------------------
// csvfc_out_reg
// Result register that decouples the parser from the result channel.
// ----------------------------------------------------------------------------
module csvfc_out_reg
  import csvfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      res_vld,
  input  out_item_t res,
  output logic      adv,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      vld_r;
  out_item_t data_r;

  assign adv = !vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_vld) begin
      data_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for csv_field_classifier. CSV lines go in one byte
// per item; a built-in predictor types every field, and each result is
// compared field by field against the oldest predicted field. The run covers
// directed corner lines, several field counts, random lines under varying
// idle patterns and a long output stall.
// ----------------------------------------------------------------------------
module tb;
  import csvfc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 500000;

  typedef enum logic [1:0] {AT_FIELD_START, IN_RAW, IN_QUOTES, AFTER_QUOTE} parse_phase_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [FIELD_CNT_W-1:0] cfg_wr_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_item_t               in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_data;

  csv_field_classifier u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // Predictor state.
  logic [FIELD_CNT_W-1:0] field_cfg = 5'd16;
  parse_phase_t           phase;
  int unsigned            fields_done;
  logic [31:0]            content_len;
  logic [31:0]            content_hash;
  logic                   minus_seen;
  logic [63:0]            digit_acc;
  logic                   maybe_int;
  logic                   was_quoted;
  logic                   had_doubled;
  logic [63:0]            packed_chars;
  logic [31:0]            content_base;

  out_item_t   expected_fields[$];
  logic [7:0]  line_buf[$];

  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned items_sent = 0;
  int unsigned lines_sent = 0;
  int unsigned results_checked = 0;
  int unsigned settings_used = 0;
  logic [31:0] next_offset = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic report_error(string msg);
    error_count++;
    if (error_count <= 40) begin
      $display("%0t error: %s", $time, msg);
    end
  endtask

  function automatic int unsigned field_limit();
    if (field_cfg < 1) return 1;
    if (field_cfg > MAX_FIELDS) return MAX_FIELDS;
    return field_cfg;
  endfunction

  task automatic clear_field_state();
    phase        = AT_FIELD_START;
    content_len  = '0;
    content_hash = HASH_SEED;
    minus_seen   = 1'b0;
    digit_acc    = '0;
    maybe_int    = 1'b1;
    was_quoted   = 1'b0;
    had_doubled  = 1'b0;
    packed_chars = '0;
    content_base = '0;
  endtask

  task automatic reset_model();
    field_cfg   = 5'd16;
    fields_done = 0;
    clear_field_state();
  endtask

  task automatic absorb_char(logic [7:0] b);
    logic [31:0] pos;
    logic        is_digit;
    pos = content_len;
    is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    if (pos < SHORT_LIMIT) packed_chars |= 64'(b) << (8 * pos);
    if (content_len != 32'hFFFF_FFFF) content_len++;
    content_hash = ((content_hash << HASH_SHIFT) + content_hash) ^ {{24{b[7]}}, b};
    if (maybe_int) begin
      if (pos == 0) begin
        if (b == CH_PLUS) minus_seen = 1'b0;
        else if (b == CH_MINUS) minus_seen = 1'b1;
        else if (is_digit) digit_acc = 64'(b - CH_ZERO);
        else maybe_int = 1'b0;
      end else if (is_digit) begin
        digit_acc = digit_acc * 10 + 64'(b - CH_ZERO);
      end else begin
        maybe_int = 1'b0;
      end
    end
  endtask

  task automatic expect_field(logic [2:0] kind, logic [2:0] slen, logic [31:0] h,
                              logic [63:0] v, logic [31:0] soff, logic [31:0] len);
    out_item_t r;
    r.field_kind    = kind;
    r.short_length  = slen;
    r.field_hash    = h;
    r.field_value   = v;
    r.string_offset = soff;
    r.string_length = len;
    r.field_number  = fields_done[3:0];
    r.line_done     = (fields_done + 1 == field_limit());
    fields_done++;
    expected_fields.push_back(r);
  endtask

  task automatic close_field();
    if (fields_done >= field_limit()) begin
      clear_field_state();
      return;
    end
    if (content_len == 0 && !was_quoted) begin
      expect_field(KIND_NULL, '0, '0, '0, '0, '0);
    end else if (maybe_int) begin
      expect_field(KIND_INT, '0, content_hash, minus_seen ? 64'd0 - digit_acc : digit_acc,
                   '0, '0);
    end else if (content_len < SHORT_LIMIT) begin
      expect_field(KIND_SHORT, content_len[2:0], content_hash, packed_chars, '0, '0);
    end else begin
      expect_field(had_doubled ? KIND_QUOTED : KIND_RAW, '0, content_hash, '0,
                   content_base, content_len);
    end
    clear_field_state();
  endtask

  task automatic close_line();
    if (phase != AT_FIELD_START) close_field();
    while (fields_done < field_limit()) begin
      expect_field(KIND_NULL, '0, '0, '0, '0, '0);
    end
    clear_field_state();
    fields_done = 0;
  endtask

  task automatic classify_item(in_item_t it);
    logic [7:0] b;
    logic       sep;
    b = it.data_byte;
    sep = (b == CH_COMMA) || (b == CH_NEWLINE);
    if (it.mode) begin
      close_line();
      return;
    end
    if (fields_done < field_limit()) begin
      case (phase)
        AT_FIELD_START: begin
          if (sep) begin
            close_field();
          end else if (b == CH_QUOTE) begin
            was_quoted   = 1'b1;
            maybe_int    = 1'b0;
            content_base = it.byte_offset + 1;
            phase        = IN_QUOTES;
          end else begin
            content_base = it.byte_offset;
            absorb_char(b);
            phase = IN_RAW;
          end
        end
        IN_RAW: begin
          if (sep) close_field();
          else absorb_char(b);
        end
        IN_QUOTES: begin
          if (b == CH_QUOTE) phase = AFTER_QUOTE;
          else absorb_char(b);
        end
        default: begin
          if (b == CH_QUOTE) begin
            absorb_char(b);
            had_doubled = 1'b1;
            phase = IN_QUOTES;
          end else if (sep) begin
            close_field();
          end else begin
            expect_field(KIND_ERROR, '0, '0, '0, '0, '0);
            clear_field_state();
          end
        end
      endcase
    end
    if (it.last_in_line) close_line();
  endtask

  task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      report_error($sformatf("result %0d %s: got %h, want %h", results_checked, name,
                             got, want));
    end
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (expected_fields.size() == 0) begin
      report_error($sformatf("unexpected result for field %0d", got.field_number));
      return;
    end
    want = expected_fields.pop_front();
    results_checked++;
    compare_field("field_kind", got.field_kind, want.field_kind);
    compare_field("short_length", got.short_length, want.short_length);
    compare_field("field_hash", got.field_hash, want.field_hash);
    compare_field("field_value", got.field_value, want.field_value);
    compare_field("string_offset", got.string_offset, want.string_offset);
    compare_field("string_length", got.string_length, want.string_length);
    compare_field("field_number", got.field_number, want.field_number);
    compare_field("line_done", got.line_done, want.line_done);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_model();
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      if (cfg_wr_en) field_cfg = cfg_wr_data;
      if (in_valid && in_ready) classify_item(in_data);
    end
  end

  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b, bit ends_line);
    in_item_t it;
    it.mode         = 1'b0;
    it.data_byte    = b;
    it.byte_offset  = next_offset;
    it.last_in_line = ends_line;
    next_offset++;
    send_item(it);
  endtask

  task automatic send_break();
    in_item_t it;
    it.mode         = 1'b1;
    it.data_byte    = 8'($urandom_range(0, 255));
    it.byte_offset  = next_offset;
    it.last_in_line = 1'($urandom_range(0, 1));
    send_item(it);
  endtask

  task automatic send_text(string s, bit ends_line);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], ends_line && (i == s.len() - 1));
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_fields.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_field_count(logic [FIELD_CNT_W-1:0] count);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= count;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  task automatic hold_results(int unsigned cycles);
    @(negedge clk);
    hold_left = cycles;
    @(posedge clk);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_COMMA || c == CH_NEWLINE || c == CH_QUOTE);
    return c;
  endfunction

  task automatic append_quoted_body(int unsigned n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: begin
          line_buf.push_back(CH_QUOTE);
          line_buf.push_back(CH_QUOTE);
        end
        1: line_buf.push_back($urandom_range(0, 1) ? CH_COMMA : CH_NEWLINE);
        default: line_buf.push_back(plain_char());
      endcase
    end
  endtask

  task automatic append_field(output bit open_quote);
    int unsigned sign_sel;
    int unsigned n;
    open_quote = 1'b0;
    case ($urandom_range(0, 9))
      0: ;
      1, 2: begin
        sign_sel = $urandom_range(0, 3);
        if (sign_sel == 1) line_buf.push_back(CH_PLUS);
        if (sign_sel == 2) line_buf.push_back(CH_MINUS);
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 22) : $urandom_range(0, 4);
        if (n == 0 && sign_sel == 0) n = 1;
        repeat (n) line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end
      3: repeat ($urandom_range(1, 7)) line_buf.push_back(plain_char());
      4: begin
        repeat ($urandom_range(8, 24)) begin
          line_buf.push_back(($urandom_range(0, 9) == 0) ? CH_QUOTE : plain_char());
        end
      end
      5, 6: begin
        line_buf.push_back(CH_QUOTE);
        append_quoted_body($urandom_range(0, 12));
        line_buf.push_back(CH_QUOTE);
      end
      7: begin
        line_buf.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 3)) line_buf.push_back(plain_char());
        line_buf.push_back(CH_QUOTE);
        line_buf.push_back(plain_char());
        repeat ($urandom_range(0, 3)) line_buf.push_back(plain_char());
      end
      8: begin
        line_buf.push_back(CH_QUOTE);
        append_quoted_body($urandom_range(1, 12));
        open_quote = 1'b1;
      end
      default: repeat ($urandom_range(1, 6)) line_buf.push_back(8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic send_random_line();
    int unsigned nf;
    bit          open_quote;
    bit          cut;
    line_buf.delete();
    if ($urandom_range(0, 15) == 0) begin
      next_offset = $urandom_range(0, 1) ? 32'($urandom()) : 32'hFFFF_FFF0;
    end
    nf = $urandom_range(0, field_limit() + 2);
    for (int i = 0; i < nf; i++) begin
      if (i > 0) line_buf.push_back(($urandom_range(0, 7) == 0) ? CH_NEWLINE : CH_COMMA);
      append_field(open_quote);
      if (open_quote) break;
    end
    cut = (line_buf.size() > 0) && ($urandom_range(0, 9) == 0);
    if (line_buf.size() == 0) begin
      send_break();
    end else begin
      foreach (line_buf[j]) send_byte(line_buf[j], !cut && (j == line_buf.size() - 1));
      if (cut) send_break();
    end
    lines_sent++;
  endtask

  task automatic send_random_lines(int unsigned n_items);
    int unsigned target;
    target = items_sent + n_items;
    while (items_sent < target) send_random_line();
  endtask

  task automatic test_corner_lines();
    send_idle = 27;
    recv_idle = 72;
    send_text("\"a\"x\n-7", 1'b1);
    send_text("\"\",+", 1'b1);
    send_break();
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b1);
    next_offset = 32'hFFFF_FFFF;
    send_text("\"12345678", 1'b1);
    wait_drained();
  endtask

  task automatic test_count_change();
    write_field_count(5'd4);
    send_text("a,b,c", 1'b0);
    write_field_count(5'd2);
    send_text("d", 1'b1);
    write_field_count(5'd4);
    send_text("1,2", 1'b0);
    send_break();
    wait_drained();
  endtask

  task automatic test_field_counts();
    logic [FIELD_CNT_W-1:0] counts[6] = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd5, 5'd16};
    foreach (counts[i]) begin
      write_field_count(counts[i]);
      send_random_lines(15);
    end
    wait_drained();
  endtask

  task automatic test_swapped_idle();
    write_field_count(5'd7);
    send_idle = 72;
    recv_idle = 27;
    send_random_lines(40);
    wait_drained();
  endtask

  task automatic test_no_idle();
    write_field_count(5'd2);
    send_idle = 0;
    recv_idle = 0;
    send_random_lines(40);
    wait_drained();
  endtask

  task automatic test_output_stall();
    write_field_count(5'd4);
    send_idle = 0;
    recv_idle = 0;
    hold_results(300);
    send_random_lines(40);
    wait_drained();
  endtask

  task automatic end_run();
    int unsigned waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_fields.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (expected_fields.size() != 0) begin
      report_error($sformatf("%0d predicted fields never came out", expected_fields.size()));
    end
    $display("Sent %0d items in %0d random lines plus corner lines; checked %0d fields.",
             items_sent, lines_sent, results_checked);
    $display("Used %0d field-count writes, three idle patterns and one long output stall.",
             settings_used);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_lines();
    test_count_change();
    test_field_counts();
    test_swapped_idle();
    test_no_idle();
    test_output_stall();
    end_run();
  end

endmodule
